@@ src/assert_macros.svh @@
// Assertion macros for the RTL, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QRPM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define QRPM_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition");
`else
`define QRPM_ASSERT(lbl, clk, rstn, prop)
`define QRPM_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ src/qrpm_pkg.sv @@
// Types, constants and the arithmetic program of the quad position mapper.
package qrpm_pkg;

    localparam int COORD_W       = 12;
    localparam int SMALL_W       = COORD_W + 1;
    localparam int OUT_W         = 24;
    localparam int FRACTION_BITS = 8;
    localparam int BED_WIDTH     = 256;
    localparam int BED_HEIGHT    = 256;
    localparam int ACC_W         = 52;
    localparam int QB            = OUT_W + 1;
    localparam int PROG_LEN      = 20;
    localparam int PC_W          = $clog2(PROG_LEN);
    localparam int BIT_W         = $clog2(SMALL_W + 1);
    localparam int CFG_IDX_W     = 3;

    localparam logic CMD_REF    = 1'b0;
    localparam logic CMD_TARGET = 1'b1;

    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [SMALL_W-1:0] t_small;
    typedef logic signed [OUT_W-1:0]   t_rel;

    typedef enum logic [1:0] {
        STAT_REF_LATCHED = 2'd0,
        STAT_REF_IGNORED = 2'd1,
        STAT_MOVE        = 2'd2,
        STAT_DEGEN       = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TL_X = 3'd0, REG_TL_Y = 3'd1, REG_TR_X = 3'd2, REG_TR_Y = 3'd3,
        REG_BL_X = 3'd4, REG_BL_Y = 3'd5, REG_BR_X = 3'd6, REG_BR_Y = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC, S_DIV_X, S_DIV_Y, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        A_YTL, A_YBL, A_XTL, A_XTR, A_EYT, A_EYB, A_EXL, A_EXR,
        A_NT, A_NB, A_NL, A_NR, A_PX, A_PY, A_T
    } t_asel;

    typedef enum logic [3:0] {
        B_DT, B_DB, B_DL, B_DR, B_PXT, B_PXB, B_PYL, B_PYR,
        B_ONE, B_BEDW, B_BEDH
    } t_bsel;

    typedef enum logic [3:0] {
        D_NONE, D_NT, D_NB, D_NL, D_NR, D_WDEN, D_HDEN, D_T, D_NUMX, D_NUMY
    } t_dest;

    typedef struct packed {
        logic  clr;
        logic  neg;
        t_asel asel;
        t_bsel bsel;
        t_dest dest;
    } t_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // acc = (clr ? 0 : acc) +/- A * B, result optionally stored
    function automatic t_op prog(input logic [PC_W-1:0] pc);
        t_op op;
        op = '{clr: 1'b1, neg: 1'b0, asel: A_T, bsel: B_ONE, dest: D_NONE};
        unique case (pc)
            5'd0:  op = '{1'b1, 1'b0, A_YTL, B_DT,   D_NONE};
            5'd1:  op = '{1'b0, 1'b0, A_EYT, B_PXT,  D_NT};
            5'd2:  op = '{1'b1, 1'b0, A_YBL, B_DB,   D_NONE};
            5'd3:  op = '{1'b0, 1'b0, A_EYB, B_PXB,  D_NB};
            5'd4:  op = '{1'b1, 1'b0, A_XTL, B_DL,   D_NONE};
            5'd5:  op = '{1'b0, 1'b0, A_EXL, B_PYL,  D_NL};
            5'd6:  op = '{1'b1, 1'b0, A_XTR, B_DR,   D_NONE};
            5'd7:  op = '{1'b0, 1'b0, A_EXR, B_PYR,  D_NR};
            5'd8:  op = '{1'b1, 1'b0, A_NR,  B_DL,   D_NONE};
            5'd9:  op = '{1'b0, 1'b1, A_NL,  B_DR,   D_WDEN};
            5'd10: op = '{1'b1, 1'b0, A_NB,  B_DT,   D_NONE};
            5'd11: op = '{1'b0, 1'b1, A_NT,  B_DB,   D_HDEN};
            5'd12: op = '{1'b1, 1'b0, A_PX,  B_DL,   D_NONE};
            5'd13: op = '{1'b0, 1'b1, A_NL,  B_ONE,  D_T};
            5'd14: op = '{1'b1, 1'b0, A_T,   B_DR,   D_T};
            5'd15: op = '{1'b1, 1'b0, A_T,   B_BEDW, D_NUMX};
            5'd16: op = '{1'b1, 1'b0, A_PY,  B_DT,   D_NONE};
            5'd17: op = '{1'b0, 1'b1, A_NT,  B_ONE,  D_T};
            5'd18: op = '{1'b1, 1'b0, A_T,   B_DB,   D_T};
            5'd19: op = '{1'b1, 1'b0, A_T,   B_BEDH, D_NUMY};
            default: op = '{1'b1, 1'b0, A_T, B_ONE, D_NONE};
        endcase
        return op;
    endfunction

endpackage

@@ src/quad_relative_position_mapper_top.sv @@
// Top level of the quad relative position mapper: config, sequencer, serial MAC, output.
//
// Maps a pixel point inside the configured quadrilateral to bed coordinates.
// Configuration: write corner registers 0..7 through i_cfg_we/i_cfg_index/
// i_cfg_data while the block is idle; writes take effect at once.
// Input channel (i_in_valid/o_in_ready): command 0 is a reference point, the
// first non-degenerate one after reset latches the origin; command 1 is a target point.
// Output channel (o_out_valid/i_out_ready): one result per input transaction
// with status, move_x and move_y.
// Sequence: a mapped point runs 20 multiply-accumulate steps in a bit-serial
// shift-add multiplier, then two passes of a bit-serial divider (skipped when
// a denominator is zero) and the output state. A new point is accepted only
// in the idle state, so one point is finished before the next is taken.
// A repeated reference or a degenerate corner set goes from idle straight to
// the output state.
// Reset clears corners, origin and all control state.
// If the receiver stalls, the finished result waits in the output register;
// the next point may be accepted and computed, and its result holds until
// the output register frees up.
module quad_relative_position_mapper_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [qrpm_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [qrpm_pkg::COORD_W-1:0]            i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_command,
    input  logic [qrpm_pkg::COORD_W-1:0]            i_point_x,
    input  logic [qrpm_pkg::COORD_W-1:0]            i_point_y,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [1:0]                              o_status,
    output logic signed [qrpm_pkg::OUT_W-1:0]       o_move_x,
    output logic signed [qrpm_pkg::OUT_W-1:0]       o_move_y
);
    import qrpm_pkg::*;
    `include "assert_macros.svh"

    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(SMALL_W);
    localparam logic [PC_W-1:0]  LAST_PC  = PC_W'(PROG_LEN - 1);

    function automatic t_small sub_c(input logic [COORD_W-1:0] a,
                                     input logic [COORD_W-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    function automatic t_rel sat_diff(input t_rel a, input t_rel b);
        logic signed [OUT_W:0] d;
        d = {a[OUT_W-1], a} - {b[OUT_W-1], b};
        if (d[OUT_W] != d[OUT_W-1]) return d[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                    : {1'b0, {(OUT_W-1){1'b1}}};
        return d[OUT_W-1:0];
    endfunction

    logic [COORD_W-1:0] r_corner [8];
    t_state             r_state, n_state;
    logic               r_cmd;
    logic [COORD_W-1:0] r_px, r_py;
    logic [PC_W-1:0]    r_pc;
    logic [BIT_W-1:0]   r_bit;
    t_acc               r_acc, r_mcand, n_acc, term;
    t_small             r_mplier;
    t_acc               r_nt, r_nb, r_nl, r_nr, r_wden, r_hden, r_t, r_numx, r_numy;
    t_rel               r_rx, r_orx, r_ory;
    logic               r_latched;
    t_status            r_res_status;
    t_rel               r_res_mx, r_res_my;
    logic               r_out_valid;
    logic [1:0]         r_o_status;
    t_rel               r_o_mx, r_o_my;

    t_op        op;
    t_acc       a_val;
    t_small     b_val;
    t_small     dt, db, dl, dr;
    logic       edge_zero, mac_last, out_free, div_start;
    t_div_stat  div_stat;
    t_rel       div_rel;
    t_acc       div_num, div_den;

    // corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_corner[i] <= '0;
        end else if (i_cfg_we) begin
            r_corner[i_cfg_index] <= i_cfg_data;
        end
    end

    assign dt = sub_c(r_corner[REG_TR_X], r_corner[REG_TL_X]);
    assign db = sub_c(r_corner[REG_BR_X], r_corner[REG_BL_X]);
    assign dl = sub_c(r_corner[REG_BL_Y], r_corner[REG_TL_Y]);
    assign dr = sub_c(r_corner[REG_BR_Y], r_corner[REG_TR_Y]);
    assign edge_zero = (dt == '0) || (db == '0) || (dl == '0) || (dr == '0);

    assign op = prog(r_pc);

    always_comb begin
        unique case (op.asel)
            A_YTL: a_val = ACC_W'($signed({1'b0, r_corner[REG_TL_Y]}));
            A_YBL: a_val = ACC_W'($signed({1'b0, r_corner[REG_BL_Y]}));
            A_XTL: a_val = ACC_W'($signed({1'b0, r_corner[REG_TL_X]}));
            A_XTR: a_val = ACC_W'($signed({1'b0, r_corner[REG_TR_X]}));
            A_EYT: a_val = ACC_W'(sub_c(r_corner[REG_TR_Y], r_corner[REG_TL_Y]));
            A_EYB: a_val = ACC_W'(sub_c(r_corner[REG_BR_Y], r_corner[REG_BL_Y]));
            A_EXL: a_val = ACC_W'(sub_c(r_corner[REG_BL_X], r_corner[REG_TL_X]));
            A_EXR: a_val = ACC_W'(sub_c(r_corner[REG_BR_X], r_corner[REG_TR_X]));
            A_NT:  a_val = r_nt;
            A_NB:  a_val = r_nb;
            A_NL:  a_val = r_nl;
            A_NR:  a_val = r_nr;
            A_PX:  a_val = ACC_W'($signed({1'b0, r_px}));
            A_PY:  a_val = ACC_W'($signed({1'b0, r_py}));
            A_T:   a_val = r_t;
            default: a_val = r_t;
        endcase
        unique case (op.bsel)
            B_DT:   b_val = dt;
            B_DB:   b_val = db;
            B_DL:   b_val = dl;
            B_DR:   b_val = dr;
            B_PXT:  b_val = sub_c(r_px, r_corner[REG_TL_X]);
            B_PXB:  b_val = sub_c(r_px, r_corner[REG_BL_X]);
            B_PYL:  b_val = sub_c(r_py, r_corner[REG_TL_Y]);
            B_PYR:  b_val = sub_c(r_py, r_corner[REG_TR_Y]);
            B_ONE:  b_val = SMALL_W'(1);
            B_BEDW: b_val = SMALL_W'(BED_WIDTH);
            B_BEDH: b_val = SMALL_W'(BED_HEIGHT);
            default: b_val = SMALL_W'(1);
        endcase
    end

    // shift-add step; the multiplier's sign bit carries negative weight
    assign term  = r_mplier[0] ? r_mcand : '0;
    assign n_acc = ((r_bit == LAST_BIT) ^ op.neg) ? r_acc - term : r_acc + term;
    assign mac_last = (r_state == S_MAC) && (r_pc == LAST_PC) && (r_bit == LAST_BIT);

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAC) begin
            if (r_bit == '0) begin
                r_mcand  <= a_val;
                r_mplier <= b_val;
                if (op.clr) r_acc <= '0;
            end else begin
                r_acc    <= n_acc;
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >>> 1;
                if (r_bit == LAST_BIT) begin
                    unique case (op.dest)
                        D_NONE: ;
                        D_NT:   r_nt   <= n_acc;
                        D_NB:   r_nb   <= n_acc;
                        D_NL:   r_nl   <= n_acc;
                        D_NR:   r_nr   <= n_acc;
                        D_WDEN: r_wden <= n_acc;
                        D_HDEN: r_hden <= n_acc;
                        D_T:    r_t    <= n_acc;
                        D_NUMX: r_numx <= n_acc;
                        D_NUMY: r_numy <= n_acc;
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_bit <= '0;
        end else if (r_state != S_MAC) begin
            r_pc  <= '0;
            r_bit <= '0;
        end else if (r_bit == LAST_BIT) begin
            r_bit <= '0;
            r_pc  <= r_pc + 1'b1;
        end else begin
            r_bit <= r_bit + 1'b1;
        end
    end

    assign div_num = (r_state == S_MAC) ? r_numx : r_numy;
    assign div_den = (r_state == S_MAC) ? r_wden : r_hden;

    qrpm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_rel   (div_rel)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if ((i_command == CMD_REF && r_latched) || edge_zero) n_state = S_OUT;
                    else                                                 n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (mac_last) begin
                    if (r_wden == '0 || r_hden == '0) begin
                        n_state = S_OUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV_X;
                    end
                end
            end
            S_DIV_X: begin
                if (div_stat.done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV_Y;
                end
            end
            S_DIV_Y: if (div_stat.done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // point capture and pending result
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd    <= i_command;
            r_px     <= i_point_x;
            r_py     <= i_point_y;
            r_res_mx <= '0;
            r_res_my <= '0;
            if (i_command == CMD_REF && r_latched) r_res_status <= STAT_REF_IGNORED;
            else                                   r_res_status <= STAT_DEGEN;
        end
        if (r_state == S_DIV_X && div_stat.done) r_rx <= div_rel;
        if (r_state == S_DIV_Y && div_stat.done) begin
            if (r_cmd == CMD_REF) begin
                r_res_status <= STAT_REF_LATCHED;
            end else begin
                r_res_status <= STAT_MOVE;
                r_res_mx     <= sat_diff(div_rel, r_ory);
                r_res_my     <= sat_diff(r_orx, r_rx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= 1'b0;
            r_orx     <= '0;
            r_ory     <= '0;
        end else if (r_state == S_DIV_Y && div_stat.done && r_cmd == CMD_REF) begin
            r_latched <= 1'b1;
            r_orx     <= r_rx;
            r_ory     <= div_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_o_status <= r_res_status;
            r_o_mx     <= r_res_mx;
            r_o_my     <= r_res_my;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_move_x    = r_o_mx;
    assign o_move_y    = r_o_my;

    `QRPM_ASSERT(a_div_busy_state, i_clk, i_rst_n,
        div_stat.busy |-> (r_state == S_DIV_X || r_state == S_DIV_Y))
    `QRPM_ASSERT(a_latched_result, i_clk, i_rst_n,
        (o_out_valid && o_status == STAT_REF_LATCHED) |-> r_latched)
    `QRPM_ASSERT(a_zero_move, i_clk, i_rst_n,
        (o_out_valid && o_status != STAT_MOVE) |-> (o_move_x == '0 && o_move_y == '0))
    `QRPM_NEVER(a_start_outside_calc, i_clk, i_rst_n,
        div_start && !(r_state == S_MAC || r_state == S_DIV_X))

endmodule

@@ src/qrpm_div.sv @@
// Bit-serial restoring divider: round(|num| * 2^FRACTION_BITS / |den|), signed, saturated.
module qrpm_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  qrpm_pkg::t_acc       i_num,
    input  qrpm_pkg::t_acc       i_den,
    output qrpm_pkg::t_div_stat  o_stat,
    output qrpm_pkg::t_rel       o_rel
);
    import qrpm_pkg::*;

    localparam int REM_W = ACC_W + FRACTION_BITS + 1;
    localparam int DVS_W = ACC_W + QB;
    localparam int CNT_W = $clog2(QB + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(QB);
    localparam logic [QB-1:0] LIM_POS = QB'((1 << (OUT_W - 1)) - 1);
    localparam logic [QB-1:0] LIM_NEG = QB'(1 << (OUT_W - 1));

    logic             r_busy, r_done, r_ovf, r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [QB-1:0]    r_q;

    logic [ACC_W-1:0] num_mag, den_mag;
    logic             ge;
    logic [QB:0]      q_inc;
    logic [QB-1:0]    mag, lim;
    logic [OUT_W-1:0] smag;

    assign num_mag = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign den_mag = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
    assign ge      = DVS_W'(r_rem) >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_CNT) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
            r_rem <= {num_mag, {(FRACTION_BITS + 1){1'b0}}};
            r_dvs <= {den_mag, {QB{1'b0}}};
            r_ovf <= 1'b0;
            r_q   <= '0;
        end else if (r_busy) begin
            // first step only checks the quotient range
            if (r_cnt == '0) begin
                r_ovf <= ge;
            end else begin
                if (ge) r_rem <= r_rem - r_dvs[REM_W-1:0];
                r_q <= {r_q[QB-2:0], ge};
            end
            r_dvs <= r_dvs >> 1;
        end
    end

    // q holds one extra fraction bit: add one and drop it to round half up
    assign q_inc = {1'b0, r_q} + 1'b1;
    assign mag   = q_inc[QB:1];
    assign lim   = r_neg ? LIM_NEG : LIM_POS;
    assign smag  = (r_ovf || mag > lim) ? lim[OUT_W-1:0] : mag[OUT_W-1:0];
    assign o_rel = r_neg ? t_rel'(-smag) : t_rel'(smag);

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

@@ tb/sv/quad_relative_position_mapper_top_tb.sv @@
// Self-checking testbench for the quad relative position mapper top level.
module quad_relative_position_mapper_top_tb;
    import qrpm_pkg::*;

    typedef struct {
        logic                 command;
        logic [COORD_W-1:0]   px;
        logic [COORD_W-1:0]   py;
    } t_point_txn;

    typedef struct {
        t_status        status;
        logic [OUT_W-1:0] mx;
        logic [OUT_W-1:0] my;
    } t_move_txn;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COORD_W-1:0]   i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_command;
    logic [COORD_W-1:0]   i_point_x;
    logic [COORD_W-1:0]   i_point_y;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [1:0]           o_status;
    logic signed [OUT_W-1:0] o_move_x;
    logic signed [OUT_W-1:0] o_move_y;

    quad_relative_position_mapper_top dut (.*);

    t_point_txn point_queue[$];
    t_move_txn  expected_moves[$];
    longint     quad_corner[8];
    bit         origin_set;
    longint     origin_x, origin_y;
    int         send_idle_pct, recv_idle_pct;
    int         recv_hold;
    int         error_count;
    int         quiet_cycles;

    localparam int WATCHDOG_LIMIT = 40000;

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic longint sat24(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // round(num * 2^FRACTION_BITS / den), half away from zero, saturated
    function automatic longint scaled_div(longint num, longint den);
        bit neg;
        longint unsigned un, ud, q, r, mag;
        longint v;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = un / ud;
        r = un % ud;
        if (q >= (64'd1 << 24)) begin
            mag = 64'd1 << 24;
        end else begin
            mag = ((q << (FRACTION_BITS + 1)) + ((r << (FRACTION_BITS + 1)) / ud) + 1) >> 1;
            if (mag > (64'd1 << 24)) mag = 64'd1 << 24;
        end
        v = longint'(mag);
        return sat24(neg ? -v : v);
    endfunction

    function automatic bit bed_position(longint px, longint py,
                                        output longint rx, output longint ry);
        longint xtl, ytl, xtr, ytr, xbl, ybl, xbr, ybr;
        longint dt, db, dl, dr, nt, nb, nl, nr, wden, hden;
        xtl = quad_corner[REG_TL_X]; ytl = quad_corner[REG_TL_Y];
        xtr = quad_corner[REG_TR_X]; ytr = quad_corner[REG_TR_Y];
        xbl = quad_corner[REG_BL_X]; ybl = quad_corner[REG_BL_Y];
        xbr = quad_corner[REG_BR_X]; ybr = quad_corner[REG_BR_Y];
        rx = 0; ry = 0;
        dt = xtr - xtl; db = xbr - xbl; dl = ybl - ytl; dr = ybr - ytr;
        if (dt == 0 || db == 0 || dl == 0 || dr == 0) return 1'b0;
        nt = ytl * dt + (ytr - ytl) * (px - xtl);
        nb = ybl * db + (ybr - ybl) * (px - xbl);
        nl = xtl * dl + (xbl - xtl) * (py - ytl);
        nr = xtr * dr + (xbr - xtr) * (py - ytr);
        wden = nr * dl - nl * dr;
        hden = nb * dt - nt * db;
        if (wden == 0 || hden == 0) return 1'b0;
        rx = scaled_div((px * dl - nl) * dr * BED_WIDTH, wden);
        ry = scaled_div((py * dt - nt) * db * BED_HEIGHT, hden);
        return 1'b1;
    endfunction

    function automatic t_move_txn predict_move(t_point_txn p);
        t_move_txn m;
        longint rx, ry;
        bit ok;
        m.mx = '0;
        m.my = '0;
        ok = bed_position(longint'(p.px), longint'(p.py), rx, ry);
        if (p.command == CMD_REF) begin
            if (origin_set) begin
                m.status = STAT_REF_IGNORED;
            end else if (ok) begin
                origin_x = rx;
                origin_y = ry;
                origin_set = 1'b1;
                m.status = STAT_REF_LATCHED;
            end else begin
                m.status = STAT_DEGEN;
            end
        end else if (ok) begin
            m.status = STAT_MOVE;
            m.mx = OUT_W'(sat24(ry - origin_y));
            m.my = OUT_W'(sat24(origin_x - rx));
        end else begin
            m.status = STAT_DEGEN;
        end
        return m;
    endfunction

    // driver: offer queued points, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                expected_moves.insert(expected_moves.size(),
                                      predict_move('{i_command, i_point_x, i_point_y}));
            if (!i_in_valid || o_in_ready) begin
                if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_point_txn p;
                    p = point_queue[0];
                    point_queue.delete(0);
                    i_in_valid <= 1'b1;
                    i_command  <= p.command;
                    i_point_x  <= p.px;
                    i_point_y  <= p.py;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, compare each result transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_moves.size() == 0) begin
                    $display("%0t: unexpected result status=%0d move_x=%0d move_y=%0d",
                             $time, o_status, o_move_x, o_move_y);
                    error_count++;
                end else begin
                    t_move_txn e;
                    e = expected_moves[0];
                    expected_moves.delete(0);
                    if (o_status !== e.status || o_move_x !== e.mx || o_move_y !== e.my) begin
                        $display("%0t: mismatch expected status=%0d x=%0d y=%0d got %0d %0d %0d",
                                 $time, e.status, $signed(e.mx), $signed(e.my),
                                 o_status, o_move_x, o_move_y);
                        error_count++;
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_corner(input t_reg_idx idx, input logic [COORD_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        quad_corner[idx] = longint'(v);
    endtask

    task automatic set_quad(input int tlx, input int tly, input int trx, input int try_,
                            input int blx, input int bly, input int brx, input int bry);
        write_corner(REG_TL_X, tlx[COORD_W-1:0]);
        write_corner(REG_TL_Y, tly[COORD_W-1:0]);
        write_corner(REG_TR_X, trx[COORD_W-1:0]);
        write_corner(REG_TR_Y, try_[COORD_W-1:0]);
        write_corner(REG_BL_X, blx[COORD_W-1:0]);
        write_corner(REG_BL_Y, bly[COORD_W-1:0]);
        write_corner(REG_BR_X, brx[COORD_W-1:0]);
        write_corner(REG_BR_Y, bry[COORD_W-1:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_point(input logic cmd, input int x, input int y);
        t_point_txn p;
        p = '{cmd, x[COORD_W-1:0], y[COORD_W-1:0]};
        point_queue.insert(point_queue.size(), p);
    endtask

    task automatic drain;
        while (point_queue.size() > 0 || i_in_valid || expected_moves.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // roughly convex quad with random content, occasionally fully random corners
    task automatic random_quad;
        if ($urandom_range(9) == 0)
            set_quad($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                     $urandom_range(4095), $urandom_range(4095));
        else
            set_quad($urandom_range(1500), $urandom_range(1500),
                     $urandom_range(2500, 4095), $urandom_range(1500),
                     $urandom_range(1500), $urandom_range(2500, 4095),
                     $urandom_range(2500, 4095), $urandom_range(2500, 4095));
    endtask

    initial begin
        error_count   = 0;
        origin_set    = 1'b0;
        origin_x      = 0;
        origin_y      = 0;
        recv_hold     = 0;
        send_idle_pct = 20;
        recv_idle_pct = 74;
        for (int i = 0; i < 8; i++) quad_corner[i] = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_command   = CMD_REF;
        i_point_x   = '0;
        i_point_y   = '0;
        i_out_ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all corners at zero: degenerate, reference must not latch
        add_point(CMD_TARGET, 4095, 4095);
        add_point(CMD_REF, 0, 0);
        drain();
        // full-range square: target before any reference, then latch and ignore
        set_quad(0, 0, 4095, 0, 0, 4095, 4095, 4095);
        add_point(CMD_TARGET, 2048, 1024);
        add_point(CMD_REF, 100, 200);
        add_point(CMD_REF, 4095, 4095);
        add_point(CMD_TARGET, 0, 0);
        add_point(CMD_TARGET, 4095, 4095);
        add_point(CMD_TARGET, 4095, 0);
        add_point(CMD_TARGET, 0, 4095);
        drain();
        // skewed quad with vertical left and right edges
        set_quad(100, 50, 3000, 400, 100, 3900, 3000, 3500);
        add_point(CMD_TARGET, 1500, 2000);
        add_point(CMD_TARGET, 100, 50);
        add_point(CMD_TARGET, 4095, 0);
        drain();
        // top edge with zero run: degenerate
        set_quad(500, 10, 500, 20, 0, 4000, 4000, 4000);
        add_point(CMD_TARGET, 1000, 1000);
        add_point(CMD_REF, 1000, 1000);
        drain();
        // one-pixel quad: far points saturate
        set_quad(0, 0, 1, 0, 0, 1, 1, 1);
        add_point(CMD_TARGET, 4095, 4095);
        add_point(CMD_TARGET, 4095, 0);
        add_point(CMD_TARGET, 0, 4095);
        drain();
        // crossed corners so that the width denominator at the point is near zero
        set_quad(0, 0, 4095, 0, 4095, 4095, 0, 4095);
        add_point(CMD_TARGET, 2048, 2048);
        add_point(CMD_TARGET, 1, 4094);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 20; recv_idle_pct = 74;
            end else if (ph < 6) begin
                send_idle_pct = 74; recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            random_quad();
            if (ph == 6) recv_hold = 3000;
            for (int n = 0; n < 156; n++) begin
                if ($urandom_range(9) < 8)
                    add_point($urandom_range(9) == 0 ? CMD_REF : CMD_TARGET,
                              $urandom_range(4095), $urandom_range(4095));
                else
                    add_point(1'($urandom_range(1)), $urandom_range(4095),
                              $urandom_range(4095));
                // pause the sender mid-phase until all results are back
                if (n == 80 && ph == 7) drain();
            end
            drain();
        end

        repeat (400) @(posedge i_clk);
        if (error_count == 0 && expected_moves.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
